/* sv/dpc_pkg.sv */
// Package for the date pair compare unit: field widths, stream bit positions,
// result codes and the constant-divisor helpers used by the datapath.
// No dependencies; every other file refers to it by scoped names.
package dpc_pkg;

   // Input field widths.
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;

   // Day number width on the result side, and the internal width of the
   // day number biased by +3 (always non-negative, holds any 14-bit year).
   localparam int DN_W  = 23;
   localparam int NUM_W = 23;

   // Input and quotient widths of the divide-by-25 and divide-by-7 helpers and the width of the leap-year count.
   localparam int Q25_IN_W = 13;
   localparam int Q25_W    = 9;
   localparam int WEEK_W   = 21;
   localparam int LEAPS_W  = 13;

   // Largest legal year.
   localparam int unsigned MAX_YEAR = 9999;

   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned DAY_BIAS      = 3;
   localparam int unsigned FEBRUARY      = 2;
   localparam int unsigned LAST_MONTH    = 12;

   // x / 25 for x below 43690 is (x * 5243) >> 17.
   localparam int unsigned DIV25_MUL   = 5243;
   localparam int unsigned DIV25_SHIFT = 17;
   // x / 7 for x below 2**23 is (x * 9586981) >> 26.
   localparam int unsigned DIV7_MUL   = 9586981;
   localparam int unsigned DIV7_SHIFT = 26;
   localparam int          DIV7_P_W   = NUM_W + 24;

   // Request tdata layout, lowest bit first.
   localparam int REQ_DATA_W = 48;
   localparam int I_FY = 0;
   localparam int I_FM = I_FY + YEAR_W;
   localparam int I_FD = I_FM + MONTH_W;
   localparam int I_SY = I_FD + DAY_W;
   localparam int I_SM = I_SY + YEAR_W;
   localparam int I_SD = I_SM + MONTH_W;

   // Response tdata layout, lowest bit first.
   localparam int RSP_DATA_W = 56;
   localparam int O_FL    = 0;
   localparam int O_SL    = 1;
   localparam int O_FDN   = 2;
   localparam int O_SDN   = O_FDN + DN_W;
   localparam int O_SWEEK = O_SDN + DN_W;
   localparam int O_SMON  = O_SWEEK + 1;
   localparam int O_SYEAR = O_SMON + 1;
   localparam int O_ORDER = O_SYEAR + 1;
   localparam int ORDER_W = 2;
   localparam int O_PAD   = O_ORDER + ORDER_W;

   typedef enum logic [ORDER_W-1:0] {
      ORDER_EQUAL   = 2'd0,
      ORDER_EARLIER = 2'd1,
      ORDER_LATER   = 2'd2
   } order_type;

   // Legality and biased day number of one date.
   typedef struct packed {
      logic             legal;
      logic [NUM_W-1:0] num;
   } date_info_type;

   // Contents of the first pipeline stage.
   typedef struct packed {
      date_info_type first;
      date_info_type second;
      logic          same_month;
      logic          same_year;
      order_type     order;
   } stage_type;

   function automatic logic [Q25_W-1:0] div25(input logic [Q25_IN_W-1:0] x);
      logic [2*Q25_IN_W-1:0] p;
      p = (2*Q25_IN_W)'(x) * (2*Q25_IN_W)'(DIV25_MUL);
      return Q25_W'(p >> DIV25_SHIFT);
   endfunction

   function automatic logic [WEEK_W-1:0] div7(input logic [NUM_W-1:0] x);
      logic [DIV7_P_W-1:0] p;
      p = DIV7_P_W'(x) * DIV7_P_W'(DIV7_MUL);
      return WEEK_W'(p >> DIV7_SHIFT);
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:                                       r = leap ? 5'd29 : 5'd28;
         default:                                    r = 5'd0;
      endcase
      return r;
   endfunction

   // Days of the whole months before month m in a common year.
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Legality and day number plus three of one date.
   function automatic date_info_type date_eval(input logic [YEAR_W-1:0]  y,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DAY_W-1:0]   d);
      logic [YEAR_W:0]    y_p3;
      logic [YEAR_W:0]    y_p99;
      logic [YEAR_W:0]    y_p399;
      logic [Q25_W-1:0]   f100;
      logic [Q25_W-1:0]   c100;
      logic [Q25_W-1:0]   f400;
      logic [Q25_W-1:0]   c400;
      logic [LEAPS_W-1:0] ceil4;
      logic [LEAPS_W-1:0] leaps;
      logic               leap;
      logic [DAY_W-1:0]   mlen;
      date_info_type      r;
      y_p3   = {1'b0, y} + (YEAR_W+1)'(3);
      y_p99  = {1'b0, y} + (YEAR_W+1)'(99);
      y_p399 = {1'b0, y} + (YEAR_W+1)'(399);
      // Floor and ceiling of y/100 and y/400; equal exactly when y divides.
      f100 = div25(Q25_IN_W'(y >> 2));
      c100 = div25(Q25_IN_W'(y_p99 >> 2));
      f400 = div25(Q25_IN_W'(y >> 4));
      c400 = div25(Q25_IN_W'(y_p399 >> 4));
      leap  = ((y[1:0] == 2'b00) && (c100 != f100)) || (c400 == f400);
      ceil4 = LEAPS_W'(y_p3 >> 2);
      // Leap years among 0 .. y-1.
      leaps = ceil4 - LEAPS_W'(c100) + LEAPS_W'(c400);
      mlen  = month_days(m, leap);
      r.legal = (32'(y) <= MAX_YEAR) && (m != '0) && (32'(m) <= LAST_MONTH) &&
                (d != '0) && (d <= mlen);
      r.num = NUM_W'(y) * NUM_W'(DAYS_PER_YEAR) + NUM_W'(leaps) +
              NUM_W'(days_before(m)) + NUM_W'(leap && (32'(m) > FEBRUARY)) +
              NUM_W'(d);
      return r;
   endfunction

endpackage

/* sv/date_pair_compare_unit.sv */
// Date pair compare unit: two-stage streaming datapath that checks two
// Gregorian dates, computes their day numbers and compares them.
// Depends on dpc_pkg for widths, field layout and the arithmetic helpers.

// Usage
// The request channel (req_) carries one pair of dates per transfer. The
// response channel (rsp_) returns one result per request, in request order:
// legality flags, day numbers (day count from year 0, minus three, or zero
// for an illegal date), same-week, same-month and same-year flags and the
// ordering code. There is no configuration port.
// Throughput is one transfer per clock cycle on both channels unless the
// receiver stalls. A taken request is registered in the first stage, then
// moved into the result register behind rsp_tvalid. The first stage computes
// legality and day numbers; the result register holds the week compare, which
// needs its own constant-reciprocal multiplier after the day-number adder.
// When the receiver stalls, the result register holds its transfer steady and
// the first stage still takes one more request, so req_tready drops only
// when both stages are full. reset (synchronous, active high) empties both
// stages; payload registers are not cleared.
module date_pair_compare_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // first_year, first_month, first_day, second_year, second_month,
   // second_day, then two zero bits
   input  logic [dpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // first_legal, second_legal, first_day_number, second_day_number,
   // same_week, same_month, same_year, order, then three zero bits
   output logic [dpc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic                           stage_valid_ff;
   logic                           stage_valid_in;
   dpc_pkg::stage_type             stage_ff;
   dpc_pkg::stage_type             stage_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [dpc_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [dpc_pkg::RSP_DATA_W-1:0] rsp_data_in;

   logic                           out_free;
   logic                           stage_move;
   logic                           req_accept;

   logic [dpc_pkg::YEAR_W-1:0]     fy;
   logic [dpc_pkg::MONTH_W-1:0]    fm;
   logic [dpc_pkg::DAY_W-1:0]      fd;
   logic [dpc_pkg::YEAR_W-1:0]     sy;
   logic [dpc_pkg::MONTH_W-1:0]    sm;
   logic [dpc_pkg::DAY_W-1:0]      sd;

   logic [dpc_pkg::NUM_W:0]        first_signed;
   logic [dpc_pkg::NUM_W:0]        second_signed;
   logic [dpc_pkg::WEEK_W-1:0]     first_week;
   logic [dpc_pkg::WEEK_W-1:0]     second_week;

   // Handshake: the result register frees up when empty or being taken, and
   // the first stage can take a request when it is empty or moving on.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_move = stage_valid_ff && out_free;
   assign req_tready = !stage_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign fy = req_tdata[dpc_pkg::I_FY +: dpc_pkg::YEAR_W];
   assign fm = req_tdata[dpc_pkg::I_FM +: dpc_pkg::MONTH_W];
   assign fd = req_tdata[dpc_pkg::I_FD +: dpc_pkg::DAY_W];
   assign sy = req_tdata[dpc_pkg::I_SY +: dpc_pkg::YEAR_W];
   assign sm = req_tdata[dpc_pkg::I_SM +: dpc_pkg::MONTH_W];
   assign sd = req_tdata[dpc_pkg::I_SD +: dpc_pkg::DAY_W];

   // First stage: legality, biased day numbers and the raw field compares.
   // The ordering compares year, month and day in priority order, which is
   // a plain compare of the concatenated fields.
   always_comb begin
      stage_in.first      = dpc_pkg::date_eval(fy, fm, fd);
      stage_in.second     = dpc_pkg::date_eval(sy, sm, sd);
      stage_in.same_year  = (fy == sy);
      stage_in.same_month = (fy == sy) && (fm == sm);
      if ({fy, fm, fd} == {sy, sm, sd}) begin
         stage_in.order = dpc_pkg::ORDER_EQUAL;
      end else if ({fy, fm, fd} < {sy, sm, sd}) begin
         stage_in.order = dpc_pkg::ORDER_EARLIER;
      end else begin
         stage_in.order = dpc_pkg::ORDER_LATER;
      end
   end

   // Second stage: remove the bias of three and form the week numbers. The
   // two days before day zero fall in week zero along with days zero to six.
   always_comb begin
      first_signed  = {1'b0, stage_ff.first.num} - (dpc_pkg::NUM_W+1)'(dpc_pkg::DAY_BIAS);
      second_signed = {1'b0, stage_ff.second.num} - (dpc_pkg::NUM_W+1)'(dpc_pkg::DAY_BIAS);
      if (first_signed[dpc_pkg::NUM_W]) begin
         first_week = '0;
      end else begin
         first_week = dpc_pkg::div7(first_signed[dpc_pkg::NUM_W-1:0]);
      end
      if (second_signed[dpc_pkg::NUM_W]) begin
         second_week = '0;
      end else begin
         second_week = dpc_pkg::div7(second_signed[dpc_pkg::NUM_W-1:0]);
      end
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[dpc_pkg::O_FL] = stage_ff.first.legal;
      rsp_data_in[dpc_pkg::O_SL] = stage_ff.second.legal;
      rsp_data_in[dpc_pkg::O_FDN +: dpc_pkg::DN_W] =
         stage_ff.first.legal ? first_signed[dpc_pkg::DN_W-1:0] : '0;
      rsp_data_in[dpc_pkg::O_SDN +: dpc_pkg::DN_W] =
         stage_ff.second.legal ? second_signed[dpc_pkg::DN_W-1:0] : '0;
      rsp_data_in[dpc_pkg::O_SWEEK] = stage_ff.first.legal && stage_ff.second.legal &&
                                      (first_week == second_week);
      rsp_data_in[dpc_pkg::O_SMON]  = stage_ff.same_month;
      rsp_data_in[dpc_pkg::O_SYEAR] = stage_ff.same_year;
      rsp_data_in[dpc_pkg::O_ORDER +: dpc_pkg::ORDER_W] = stage_ff.order;
   end

   always_comb begin
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
      if (stage_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ff <= stage_in;
      end
      if (stage_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* sv/dpc_checker.sv */
// Port-level checker for the date pair compare unit, bound to the top level.
// Depends on dpc_pkg for the response field layout and the ordering codes.
module dpc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dpc_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dpc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                         first_legal;
   logic                         same_week;
   logic                         same_month;
   logic                         same_year;
   logic [dpc_pkg::DN_W-1:0]     first_dn;
   logic [dpc_pkg::DN_W-1:0]     second_dn;
   logic [dpc_pkg::ORDER_W-1:0]  order;

   assign first_legal = rsp_tdata[dpc_pkg::O_FL];
   assign same_week   = rsp_tdata[dpc_pkg::O_SWEEK];
   assign same_month  = rsp_tdata[dpc_pkg::O_SMON];
   assign same_year   = rsp_tdata[dpc_pkg::O_SYEAR];
   assign first_dn    = rsp_tdata[dpc_pkg::O_FDN +: dpc_pkg::DN_W];
   assign second_dn   = rsp_tdata[dpc_pkg::O_SDN +: dpc_pkg::DN_W];
   assign order       = rsp_tdata[dpc_pkg::O_ORDER +: dpc_pkg::ORDER_W];

   // The result channel is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled result transfer holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An illegal first date reads day number zero and never shares a week.
   a_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !first_legal |-> (first_dn == '0) && !same_week)
      else $error("illegal date with nonzero day number or same week");

   // Equal dates agree on everything derived from them.
   a_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (order == dpc_pkg::ORDER_EQUAL) |->
         same_month && same_year && (first_dn == second_dn) && (same_week == first_legal))
      else $error("equal dates gave inconsistent result");

   // Same month implies same year, and the ordering code is never unused.
   a_month_year: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!same_month || same_year) &&
         (order == dpc_pkg::ORDER_EQUAL || order == dpc_pkg::ORDER_EARLIER ||
          order == dpc_pkg::ORDER_LATER))
      else $error("same month without same year or bad order code");

endmodule

bind date_pair_compare_unit dpc_checker u_dpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/date_pair_compare_checker.sv */
// Scoreboard for the date pair compare unit: watches both stream channels,
// computes the expected result of every request transfer and compares it.
// Depends on dpc_pkg for the stream bit layout and the ordering codes.
module date_pair_compare_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // first_year, first_month, first_day, second_year, second_month,
   // second_day, then two zero bits
   input  logic [dpc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // first_legal, second_legal, first_day_number, second_day_number,
   // same_week, same_month, same_year, order, then three zero bits
   input  logic [dpc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                             mismatch_count,
   output int                             results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                      first_legal;
      logic                      second_legal;
      logic [dpc_pkg::DN_W-1:0]  first_day_number;
      logic [dpc_pkg::DN_W-1:0]  second_day_number;
      logic                      same_week;
      logic                      same_month;
      logic                      same_year;
      dpc_pkg::order_type        ordering;
   } compare_result_type;

   compare_result_type pending_comparisons[$];

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
   end

   function automatic bit is_leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_length(int m, bit leap);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic bit is_calendar_date(int y, int m, int d);
      return (y <= dpc_pkg::MAX_YEAR) && (m >= 1) && (m <= 12) && (d >= 1) &&
             (d <= month_length(m, is_leap_year(y)));
   endfunction

   // Days since the epoch, three days early, for a legal date.
   function automatic int day_count(int y, int m, int d);
      int leap_years;
      int count;
      leap_years = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      count      = -3 + y * 365 + leap_years;
      for (int i = 1; i < m; i++)
         count += month_length(i, is_leap_year(y));
      return count + d;
   endfunction

   function automatic compare_result_type compare_dates(
         logic [dpc_pkg::REQ_DATA_W-1:0] word);
      int y1, m1, d1, y2, m2, d2, n1, n2;
      compare_result_type r;
      y1 = word[dpc_pkg::I_FY +: dpc_pkg::YEAR_W];
      m1 = word[dpc_pkg::I_FM +: dpc_pkg::MONTH_W];
      d1 = word[dpc_pkg::I_FD +: dpc_pkg::DAY_W];
      y2 = word[dpc_pkg::I_SY +: dpc_pkg::YEAR_W];
      m2 = word[dpc_pkg::I_SM +: dpc_pkg::MONTH_W];
      d2 = word[dpc_pkg::I_SD +: dpc_pkg::DAY_W];
      r.first_legal  = is_calendar_date(y1, m1, d1);
      r.second_legal = is_calendar_date(y2, m2, d2);
      n1 = r.first_legal ? day_count(y1, m1, d1) : 0;
      n2 = r.second_legal ? day_count(y2, m2, d2) : 0;
      r.first_day_number  = n1[dpc_pkg::DN_W-1:0];
      r.second_day_number = n2[dpc_pkg::DN_W-1:0];
      // Integer division truncates toward zero, so day numbers -2 .. 6 all
      // land in week zero.
      r.same_week  = r.first_legal && r.second_legal && (n1 / 7 == n2 / 7);
      r.same_month = (y1 == y2) && (m1 == m2);
      r.same_year  = (y1 == y2);
      if (y1 != y2)
         r.ordering = (y1 < y2) ? dpc_pkg::ORDER_EARLIER : dpc_pkg::ORDER_LATER;
      else if (m1 != m2)
         r.ordering = (m1 < m2) ? dpc_pkg::ORDER_EARLIER : dpc_pkg::ORDER_LATER;
      else if (d1 != d2)
         r.ordering = (d1 < d2) ? dpc_pkg::ORDER_EARLIER : dpc_pkg::ORDER_LATER;
      else
         r.ordering = dpc_pkg::ORDER_EQUAL;
      return r;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      compare_result_type want;
      logic [dpc_pkg::RSP_DATA_W-1:0] got;
      if (!reset) begin
         // Retire first: a response can never belong to a request taken at
         // the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_comparisons.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_comparisons.pop_front();
               check_field("first_legal", want.first_legal, got[dpc_pkg::O_FL]);
               check_field("second_legal", want.second_legal, got[dpc_pkg::O_SL]);
               check_field("first_day_number", int'($signed(want.first_day_number)),
                           int'($signed(got[dpc_pkg::O_FDN +: dpc_pkg::DN_W])));
               check_field("second_day_number", int'($signed(want.second_day_number)),
                           int'($signed(got[dpc_pkg::O_SDN +: dpc_pkg::DN_W])));
               check_field("same_week", want.same_week, got[dpc_pkg::O_SWEEK]);
               check_field("same_month", want.same_month, got[dpc_pkg::O_SMON]);
               check_field("same_year", want.same_year, got[dpc_pkg::O_SYEAR]);
               check_field("order", want.ordering,
                           got[dpc_pkg::O_ORDER +: dpc_pkg::ORDER_W]);
            end
         end
         if (req_tvalid && req_tready)
            pending_comparisons.push_back(compare_dates(req_tdata));
      end
      results_outstanding = pending_comparisons.size();
   end

endmodule

/* tb/date_pair_compare_unit_test.sv */
// Top of the date pair compare unit testbench: clock, reset, request stimulus
// with random idling, random response back-pressure and the final verdict.
// Depends on dpc_pkg, date_pair_compare_unit and date_pair_compare_checker.
module date_pair_compare_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Far above the slowest legal run: roughly 575 transfers, each of them slowed
   // by random sender gaps and receiver stalls.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Random transfers per idling phase; four phases give about 550.
   localparam int RANDOM_PER_PHASE = 138;
   // Cycles allowed after the last response, well past the two-stage latency.
   localparam int DRAIN_CYCLES = 10;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [dpc_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dpc_pkg::RSP_DATA_W-1:0] rsp_tdata;

   int          mismatch_count;
   int          results_outstanding;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int unsigned cycle_count        = 0;

   date_pair_compare_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   date_pair_compare_checker scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver decides once per falling edge whether it accepts a
   // transfer, so tready never gets two updates in one time step.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

   // Length of a month in the requested calendar, used only to aim the
   // random days at legal dates and their borders.
   function automatic int month_days(int y, int m);
      bit leap;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      case (m)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // Years are biased toward the ends of the legal range and toward the
   // century and quad-century years where the leap rule changes.
   function automatic int pick_year();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 3);
         1:       return $urandom_range(9990, 9999);
         2:       return 100 * $urandom_range(0, 99);
         3:       return 4 * $urandom_range(0, 2499);
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   // Mostly legal dates; the rest are raw field values and dates that break
   // one rule at a time (day zero, day past month end, bad month, year
   // past the maximum).
   task automatic pick_date(output int y, output int m, output int d);
      int kind;
      kind = $urandom_range(0, 19);
      y    = pick_year();
      m    = $urandom_range(1, 12);
      d    = $urandom_range(1, month_days(y, m));
      case (kind)
         14, 15: begin
            y = $urandom_range(0, 16383);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
         end
         16: d = 0;
         17: begin
            case ($urandom_range(0, 4))
               0:       m = 2;
               1:       m = 4;
               2:       m = 6;
               3:       m = 9;
               default: m = 11;
            endcase
            d = month_days(y, m) + 1;
         end
         18: m = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(13, 15);
         19: y = $urandom_range(10000, 16383);
         default: ;
      endcase
   endtask

   // Offers one pair of dates and returns at the falling edge after the
   // transfer. Called at a falling edge; the sender may first sit idle.
   task automatic send_pair(int y1, int m1, int d1, int y2, int m2, int d2);
      logic [dpc_pkg::REQ_DATA_W-1:0] word;
      word = '0;
      word[dpc_pkg::I_FY +: dpc_pkg::YEAR_W]  = y1[dpc_pkg::YEAR_W-1:0];
      word[dpc_pkg::I_FM +: dpc_pkg::MONTH_W] = m1[dpc_pkg::MONTH_W-1:0];
      word[dpc_pkg::I_FD +: dpc_pkg::DAY_W]   = d1[dpc_pkg::DAY_W-1:0];
      word[dpc_pkg::I_SY +: dpc_pkg::YEAR_W]  = y2[dpc_pkg::YEAR_W-1:0];
      word[dpc_pkg::I_SM +: dpc_pkg::MONTH_W] = m2[dpc_pkg::MONTH_W-1:0];
      word[dpc_pkg::I_SD +: dpc_pkg::DAY_W]   = d2[dpc_pkg::DAY_W-1:0];
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Random pair: the second date is often a copy of the first or close to
   // it, so same-week, same-month and year-boundary cases come up often.
   task automatic send_random_pair();
      int y1, m1, d1, y2, m2, d2, relation, t;
      pick_date(y1, m1, d1);
      pick_date(y2, m2, d2);
      relation = $urandom_range(0, 9);
      case (relation)
         0, 1: begin
            y2 = y1;
            m2 = m1;
            d2 = d1;
         end
         2, 3, 4: begin
            y2 = y1;
            m2 = (relation == 4) ? $urandom_range(1, 12) : m1;
            d2 = d1 + $urandom_range(0, 12) - 6;
            if (d2 < 1) d2 = 1;
            if (d2 > 31) d2 = 31;
         end
         5: begin
            // Across a new year, where week buckets may still match.
            y1 = $urandom_range(0, 9998);
            m1 = 12;
            d1 = $urandom_range(24, 31);
            y2 = y1 + 1;
            m2 = 1;
            d2 = $urandom_range(1, 7);
         end
         default: ;
      endcase
      if ($urandom_range(0, 1)) begin
         t = y1; y1 = y2; y2 = t;
         t = m1; m1 = m2; m2 = t;
         t = d1; d1 = d2; d2 = t;
      end
      send_pair(y1, m1, d1, y2, m2, d2);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed transfers with no idling on either side.
      send_pair(0, 1, 1, 0, 1, 1);          // earliest date, equal pair
      send_pair(0, 1, 1, 0, 1, 9);          // day numbers -2 and 6 share week 0
      send_pair(0, 1, 9, 0, 1, 10);         // day 6 against day 7
      send_pair(9999, 12, 31, 9999, 12, 31);
      send_pair(16383, 15, 31, 16383, 15, 31); // all ones, both illegal
      send_pair(0, 0, 0, 0, 0, 0);          // all zeros, both illegal
      send_pair(10000, 1, 1, 9999, 12, 31); // year just past the maximum
      send_pair(2000, 2, 29, 1900, 2, 29);  // quad-century leap, century common
      send_pair(2024, 2, 29, 2023, 2, 29);
      send_pair(2024, 2, 30, 2024, 4, 31);  // day past month end
      send_pair(2024, 1, 0, 2024, 13, 1);   // day zero, month thirteen
      send_pair(2024, 3, 1, 2024, 2, 29);
      send_pair(2024, 6, 15, 2024, 6, 14);
      send_pair(2024, 6, 15, 2024, 7, 15);
      send_pair(2023, 12, 31, 2024, 1, 1);
      send_pair(1, 1, 1, 0, 12, 31);
      send_pair(2100, 2, 29, 2400, 2, 29);
      send_pair(0, 2, 29, 4, 2, 29);        // year zero is a leap year
      send_pair(2024, 4, 30, 2024, 4, 31);
      send_pair(5000, 14, 5, 5000, 14, 5);  // illegal month, equal fields
      send_pair(16383, 1, 1, 8192, 1, 1);
      send_pair(8191, 7, 16, 9999, 8, 15);

      // Random transfers in four idling phases.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_pair();
      end
      req_tvalid <= 1'b0;

      // Wait for every response, then a little longer to catch extras.
      while (results_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* date_pair_compare_unit.f */
sv/dpc_pkg.sv
sv/date_pair_compare_unit.sv
sv/dpc_checker.sv
tb/date_pair_compare_checker.sv
tb/date_pair_compare_unit_test.sv
